// File: sv/sha_pkg.sv
// SHA-256 package: round constants, initial hash values and helper functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

   localparam int Rounds = 64;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic     busy;
      logic     done;
   } core_ctl_type;

   // request kinds
   localparam logic KindAbsorb = 1'b0;
   localparam logic KindFinish = 1'b1;

   localparam word_type RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PadByte  = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: sv/sha_if.sv
// Valid/ready channel interfaces for the hasher.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   modport source (output valid, kind, data_byte, input ready);
   modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/sha_core.sv
// SHA-256 compression core: one round per cycle over a shared round unit.
// Reads block words from the buffer owner; depends on sha_pkg.
`timescale 1ns / 1ps
module sha_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    init,
   input  sha_pkg::word_type       blk_word,
   output logic [3:0]              blk_addr,
   output sha_pkg::core_ctl_type   ctl,
   output sha_pkg::word_type       chain [8]
);
   typedef enum logic [1:0] {IDLE, ROUND, FOLD} state_type;

   state_type         state_ff;
   logic [5:0]        round_ff;
   sha_pkg::word_type wk_ff [8];
   sha_pkg::word_type sched_ff [16];
   sha_pkg::word_type chain_ff [8];
   sha_pkg::word_type w_in, t1, t2, s0, s1, ch, mj, e, a;
   logic              done_ff;

   // block words are fetched ahead of use; the top level adds one to blk_addr
   assign blk_addr = round_ff[3:0];
   assign chain    = chain_ff;
   assign ctl      = '{busy: (state_ff != IDLE), done: done_ff};

   always_comb begin
      s1 = sha_pkg::rotr(sched_ff[14], 17) ^ sha_pkg::rotr(sched_ff[14], 19)
           ^ (sched_ff[14] >> 10);
      s0 = sha_pkg::rotr(sched_ff[1], 7) ^ sha_pkg::rotr(sched_ff[1], 18)
           ^ (sched_ff[1] >> 3);
      if (round_ff < 6'd16) w_in = blk_word;
      else                  w_in = s1 + sched_ff[9] + s0 + sched_ff[0];
      a  = wk_ff[0];
      e  = wk_ff[4];
      ch = (e & wk_ff[5]) ^ (~e & wk_ff[6]);
      mj = (a & wk_ff[1]) ^ (a & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
      t1 = wk_ff[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
           + ch + sha_pkg::RoundK[round_ff] + w_in;
      t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22)) + mj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         round_ff <= '0;
         chain_ff <= sha_pkg::InitH;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == FOLD);
         case (state_ff)
            IDLE: begin
               if (init) chain_ff <= sha_pkg::InitH;
               if (start) begin
                  wk_ff    <= chain_ff;
                  round_ff <= '0;
                  state_ff <= ROUND;
               end
            end
            ROUND: begin
               // sched_ff[15] holds the newest word; shift window by one
               for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
               sched_ff[15] <= w_in;
               wk_ff[7] <= wk_ff[6];
               wk_ff[6] <= wk_ff[5];
               wk_ff[5] <= e;
               wk_ff[4] <= wk_ff[3] + t1;
               wk_ff[3] <= wk_ff[2];
               wk_ff[2] <= wk_ff[1];
               wk_ff[1] <= a;
               wk_ff[0] <= t1 + t2;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= FOLD;
            end
            FOLD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + wk_ff[i];
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// File: sv/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher top level: block buffer, padding sequencer, output.
// Depends on sha_pkg, sha_if and sha_core.
`timescale 1ns / 1ps
//  channel | dir | payload                              | handshake
//  req     | in  | kind, data_byte                      | valid/ready
//  rsp     | out | digest_word, word_index, last_word   | valid/ready
// Bytes are taken one per cycle while idle and sha_core is not busy; the 64th
// byte of a block starts a compression (one round per cycle in sha_core). A
// finish writes padding one byte per cycle, runs one or two compressions, then
// emits eight words. Reset is synchronous and restores the initial hash values;
// rsp stalls hold the sequencer and the word on the port.
module sha256_byte_stream_hasher (
   input logic         clock,
   input logic         reset,
   sha_req_if.sink     req,
   sha_rsp_if.source   rsp
);
   typedef enum logic [2:0] {IDLE, PAD, LEN, WAIT, EMIT} state_type;

   state_type               state_ff;
   logic [63:0]             len_ff;
   logic [5:0]              fill_ff;
   logic [31:0]             buf_ff [16];
   logic                    fin_ff;
   logic [2:0]              idx_ff;
   logic                    req_go_ff, req_go_in;
   logic                    start, init, wr_en;
   logic [5:0]              wr_addr;
   logic [7:0]              wr_data;
   logic [3:0]              blk_addr, rd_addr;
   sha_pkg::word_type       blk_word_ff;
   sha_pkg::core_ctl_type   ctl;
   sha_pkg::word_type       chain [8];

   sha_core u_core (
      .clock, .reset, .start, .init, .blk_word(blk_word_ff), .blk_addr, .ctl, .chain
   );

   assign start           = req_go_ff;
   assign req.ready       = (state_ff == IDLE) && !ctl.busy && !start;
   assign rsp.valid       = (state_ff == EMIT);
   assign rsp.digest_word = chain[idx_ff];
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = (idx_ff == 3'd7);
   assign init            = (state_ff == EMIT) && rsp.ready && (idx_ff == 3'd7);

   // registered block read: core asks for word n during round n-1's edge
   assign rd_addr = ctl.busy ? blk_addr + 4'd1 : 4'd0;

   always_ff @(posedge clock) begin
      blk_word_ff <= buf_ff[rd_addr];
      // first byte of a word lands in bits 31..24
      if (wr_en) buf_ff[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff;
      wr_data = 8'h00;
      case (state_ff)
         IDLE: begin
            wr_en   = req.valid && req.ready;
            wr_data = (req.kind == sha_pkg::KindFinish) ? sha_pkg::PadByte : req.data_byte;
         end
         PAD: wr_en = 1'b1;
         LEN: begin
            wr_en   = 1'b1;
            wr_data = len_ff[{~fill_ff[2:0], 3'd7} -: 8];
         end
         default: ;
      endcase
      // compress whenever the last byte of the block is written
      req_go_in = (fill_ff == 6'd63) &&
                  (((state_ff == IDLE) && req.valid && req.ready) ||
                   (state_ff == PAD) || (state_ff == LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         len_ff    <= '0;
         fill_ff   <= '0;
         fin_ff    <= 1'b0;
         idx_ff    <= '0;
         req_go_ff <= 1'b0;
      end else begin
         req_go_ff <= req_go_in;
         case (state_ff)
            IDLE: if (req.valid && req.ready) begin
               fill_ff <= fill_ff + 6'd1;
               if (req.kind == sha_pkg::KindAbsorb) begin
                  len_ff <= len_ff + 64'd8;
               end else begin
                  fin_ff <= 1'b1;
                  if (fill_ff == 6'd63)                             state_ff <= WAIT;
                  else if (fill_ff == sha_pkg::LenStart - 6'd1)     state_ff <= LEN;
                  else                                              state_ff <= PAD;
               end
            end
            PAD: begin
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63)                          state_ff <= WAIT;
               else if (fill_ff == sha_pkg::LenStart - 6'd1)  state_ff <= LEN;
            end
            LEN: begin
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  fin_ff   <= 1'b0;
                  state_ff <= WAIT;
               end
            end
            // fin_ff still set means the length did not fit and an extra padding block follows
            WAIT: if (ctl.done) state_ff <= fin_ff ? PAD : EMIT;
            EMIT: if (rsp.ready) begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_ff <= IDLE;
                  len_ff   <= '0;
                  fill_ff  <= '0;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// File: bench/sha256_byte_stream_hasher_test.sv
// Self-checking bench for sha256_byte_stream_hasher: byte messages in, digest words out.
// Depends on sha_pkg (round constants, initial hash values), sha_if and the hasher RTL.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_test;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 200;

   typedef struct {
      sha_pkg::word_type digest_word;
      logic [2:0]        word_index;
      logic              last_word;
   } digest_word_type;

   logic clock;
   logic reset;
   sha_req_if req_ch ();
   sha_rsp_if rsp_ch ();

   sha256_byte_stream_hasher u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // hasher context mirrored by the bench
   sha_pkg::word_type chain_h [8];
   logic [63:0]       msg_bits;
   logic [7:0]        block_bytes [64];

   digest_word_type pending_digest [$];
   int  fail_count;
   int  cycle_count;
   int  stall_left;
   bit  rsp_free_run;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sha_pkg::word_type ror32(sha_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void start_context();
      for (int i = 0; i < 8; i++) chain_h[i] = sha_pkg::InitH[i];
      msg_bits = '0;
   endfunction

   function automatic void compress_block();
      sha_pkg::word_type w [64];
      sha_pkg::word_type a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int k = 0; k < 64; k++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + sha_pkg::RoundK[k] + w[k];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   // absorb one byte or pad and queue the eight digest words
   function automatic void predict_digest(logic kind, logic [7:0] data_byte);
      int fill;
      digest_word_type dw;
      fill = int'(msg_bits[8:3]);
      if (kind == sha_pkg::KindAbsorb) begin
         block_bytes[fill] = data_byte;
         msg_bits += 64'd8;
         if (fill == 63) compress_block();
         return;
      end
      block_bytes[fill] = sha_pkg::PadByte;
      fill++;
      if (fill > 56) begin
         while (fill < 64) begin
            block_bytes[fill] = 8'h00;
            fill++;
         end
         compress_block();
         fill = 0;
      end
      while (fill < 56) begin
         block_bytes[fill] = 8'h00;
         fill++;
      end
      for (int i = 0; i < 8; i++) block_bytes[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         dw.digest_word = chain_h[i];
         dw.word_index  = 3'(i);
         dw.last_word   = (i == 7);
         pending_digest.push_back(dw);
      end
      start_context();
   endfunction

   // word gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 15) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(logic kind, logic [7:0] data_byte, bit no_gap = 0);
      int gap;
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.data_byte <= data_byte;
      do @(posedge clock); while (!req_ch.ready);
      predict_digest(kind, data_byte);
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_message(int len, bit no_gap = 0);
      for (int i = 0; i < len; i++)
         send_word(sha_pkg::KindAbsorb, 8'($urandom_range(0, 255)), no_gap);
      send_word(sha_pkg::KindFinish, 8'($urandom_range(0, 255)), no_gap);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_digest.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_message();
      send_word(sha_pkg::KindFinish, 8'h00);
      send_word(sha_pkg::KindFinish, 8'hff);
   endtask

   task automatic test_byte_extremes();
      send_word(sha_pkg::KindAbsorb, 8'h61);
      send_word(sha_pkg::KindAbsorb, 8'h62);
      send_word(sha_pkg::KindAbsorb, 8'h63);
      send_word(sha_pkg::KindFinish, 8'h5a);
      send_word(sha_pkg::KindAbsorb, 8'h00);
      send_word(sha_pkg::KindAbsorb, 8'hff);
      send_word(sha_pkg::KindAbsorb, 8'h55);
      send_word(sha_pkg::KindAbsorb, 8'haa);
      send_word(sha_pkg::KindFinish, 8'hff);
   endtask

   // one full block, then more than 55 bytes pending at the finish
   task automatic test_padding_boundaries();
      wait_drained();
      send_message(120);
   endtask

   task automatic test_random_messages();
      int sent;
      sent = 0;
      while (sent < 12) begin
         int len;
         len = $urandom_range(0, 6);
         send_message(len);
         sent += len + 1;
         if ($urandom_range(0, 5) == 0) wait_drained();
      end
   endtask

   task automatic test_back_to_back();
      rsp_free_run = 1'b1;
      send_message(5, 1);
      send_message(1, 1);
      wait_drained();
      rsp_free_run = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (rsp_free_run) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         case ($urandom_range(0, 15))
            0: begin
               rsp_ch.ready <= 1'b0;
               stall_left   <= $urandom_range(15, 50);
            end
            1, 2, 3: begin
               rsp_ch.ready <= 1'b0;
               stall_left   <= $urandom_range(0, 2);
            end
            default: rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      digest_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_digest.size() == 0) begin
            $error("unexpected digest word %h index %0d", rsp_ch.digest_word, rsp_ch.word_index);
            fail_count++;
         end else begin
            want = pending_digest.pop_front();
            if (rsp_ch.digest_word !== want.digest_word) begin
               $error("digest_word: expected %h, actual %h", want.digest_word, rsp_ch.digest_word);
               fail_count++;
            end
            if (rsp_ch.word_index !== want.word_index) begin
               $error("word_index: expected %0d, actual %0d", want.word_index, rsp_ch.word_index);
               fail_count++;
            end
            if (rsp_ch.last_word !== want.last_word) begin
               $error("last_word: expected %0b, actual %0b", want.last_word, rsp_ch.last_word);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      fail_count       = 0;
      cycle_count      = 0;
      rsp_free_run     = 1'b0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= sha_pkg::KindAbsorb;
      req_ch.data_byte <= 8'h00;
      start_context();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_message();
      test_byte_extremes();
      test_padding_boundaries();
      test_back_to_back();
      test_random_messages();

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_digest.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_core.sv
sv/sha256_byte_stream_hasher.sv
bench/sha256_byte_stream_hasher_test.sv
